>>> rtl/hrhp_pkg.sv
package hrhp_pkg;

  localparam int LEN_W = 13;
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] byte_class;
    logic [7:0] out_byte;
    logic [2:0] done_event;
    logic [2:0] status;
  } out_word_t;

  typedef struct packed {
    logic [7:0]       method_len;
    logic [LEN_W-1:0] uri_len;
    logic [7:0]       version_len;
    logic [LEN_W-1:0] name_len;
    logic [LEN_W-1:0] value_len;
  } limits_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_METHOD_LEN  = 3'd0,
    REG_URI_LEN     = 3'd1,
    REG_VERSION_LEN = 3'd2,
    REG_NAME_LEN    = 3'd3,
    REG_VALUE_LEN   = 3'd4
  } cfg_reg_t;

  localparam logic [7:0]       RST_METHOD_LEN  = 8'd20;
  localparam logic [LEN_W-1:0] RST_URI_LEN     = 13'd4096;
  localparam logic [7:0]       RST_VERSION_LEN = 8'd20;
  localparam logic [LEN_W-1:0] RST_NAME_LEN    = 13'd255;
  localparam logic [LEN_W-1:0] RST_VALUE_LEN   = 13'd4096;

  typedef enum logic [4:0] {
    PH_START        = 5'd0,
    PH_METHOD       = 5'd1,
    PH_MU_GAP       = 5'd2,
    PH_URI          = 5'd3,
    PH_UV_GAP       = 5'd4,
    PH_VERSION      = 5'd5,
    PH_VER_CR       = 5'd6,
    PH_VER_LF       = 5'd7,
    PH_HDR          = 5'd8,
    PH_NAME         = 5'd9,
    PH_VALUE        = 5'd10,
    PH_VALUE_LF     = 5'd11,
    PH_VALUE_LWS    = 5'd12,
    PH_END_LF       = 5'd13,
    PH_COMPLETE     = 5'd14,
    PH_BAD          = 5'd15,
    PH_LONG_METHOD  = 5'd16,
    PH_LONG_URI     = 5'd17,
    PH_LONG_VERSION = 5'd18,
    PH_LONG_NAME    = 5'd19,
    PH_LONG_VALUE   = 5'd20
  } phase_t;

  localparam logic [2:0] CLS_NONE    = 3'd0;
  localparam logic [2:0] CLS_METHOD  = 3'd1;
  localparam logic [2:0] CLS_URI     = 3'd2;
  localparam logic [2:0] CLS_VERSION = 3'd3;
  localparam logic [2:0] CLS_NAME    = 3'd4;
  localparam logic [2:0] CLS_VALUE   = 3'd5;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_METHOD   = 3'd1;
  localparam logic [2:0] EV_URI      = 3'd2;
  localparam logic [2:0] EV_VERSION  = 3'd3;
  localparam logic [2:0] EV_FIELD    = 3'd4;
  localparam logic [2:0] EV_COMPLETE = 3'd5;

  localparam logic [2:0] ST_PARSING      = 3'd0;
  localparam logic [2:0] ST_COMPLETE     = 3'd1;
  localparam logic [2:0] ST_BAD          = 3'd2;
  localparam logic [2:0] ST_LONG_METHOD  = 3'd3;
  localparam logic [2:0] ST_LONG_URI     = 3'd4;
  localparam logic [2:0] ST_LONG_VERSION = 3'd5;
  localparam logic [2:0] ST_LONG_NAME    = 3'd6;
  localparam logic [2:0] ST_LONG_VALUE   = 3'd7;

  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DEL   = 8'h7F;

endpackage

>>> rtl/hrhp_cfg.sv
module hrhp_cfg
  import hrhp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output limits_t              limits
);

  limits_t limits_r;
  limits_t limits_nxt;

  always_comb begin
    limits_nxt = limits_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_METHOD_LEN:  limits_nxt.method_len  = cfg_wdata[7:0];
        REG_URI_LEN:     limits_nxt.uri_len     = cfg_wdata[LEN_W-1:0];
        REG_VERSION_LEN: limits_nxt.version_len = cfg_wdata[7:0];
        REG_NAME_LEN:    limits_nxt.name_len    = cfg_wdata[LEN_W-1:0];
        REG_VALUE_LEN:   limits_nxt.value_len   = cfg_wdata[LEN_W-1:0];
        default:         limits_nxt = limits_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.method_len  <= RST_METHOD_LEN;
      limits_r.uri_len     <= RST_URI_LEN;
      limits_r.version_len <= RST_VERSION_LEN;
      limits_r.name_len    <= RST_NAME_LEN;
      limits_r.value_len   <= RST_VALUE_LEN;
    end else begin
      limits_r <= limits_nxt;
    end
  end

  assign limits = limits_r;

endmodule

>>> rtl/hrhp_fsm.sv
module hrhp_fsm
  import hrhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_word_t  word,
  input  limits_t   limits,
  output out_word_t result
);

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] limit;
  logic             room;
  logic [7:0]       c;
  logic             c_sp, c_vis, c_hdr, c_tok, c_cr, c_lf, c_colon;
  logic [2:0]       cls;
  logic [2:0]       ev;
  logic             fold;

  function automatic logic is_token(input logic [7:0] ch);
    logic vis;
    vis = (ch >= 8'h21) && (ch <= 8'h7E);
    case (ch)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
      8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: is_token = 1'b0;
      default: is_token = vis;
    endcase
  endfunction

  function automatic logic [2:0] status_of(input phase_t ph);
    case (ph)
      PH_COMPLETE:     status_of = ST_COMPLETE;
      PH_BAD:          status_of = ST_BAD;
      PH_LONG_METHOD:  status_of = ST_LONG_METHOD;
      PH_LONG_URI:     status_of = ST_LONG_URI;
      PH_LONG_VERSION: status_of = ST_LONG_VERSION;
      PH_LONG_NAME:    status_of = ST_LONG_NAME;
      PH_LONG_VALUE:   status_of = ST_LONG_VALUE;
      default:         status_of = ST_PARSING;
    endcase
  endfunction

  assign c       = word.in_byte;
  assign c_sp    = (c == CH_SP) || (c == CH_HT);
  assign c_vis   = (c >= 8'h21) && (c <= 8'h7E);
  assign c_hdr   = (c == CH_HT) || ((c >= CH_SP) && (c != CH_DEL));
  assign c_tok   = is_token(c);
  assign c_cr    = (c == CH_CR);
  assign c_lf    = (c == CH_LF);
  assign c_colon = (c == CH_COLON);

  // Only one field is open in any phase, so one compare serves all limits.
  always_comb begin
    case (phase_r)
      PH_METHOD:    limit = {{(LEN_W-8){1'b0}}, limits.method_len};
      PH_URI:       limit = limits.uri_len;
      PH_VERSION:   limit = {{(LEN_W-8){1'b0}}, limits.version_len};
      PH_NAME:      limit = limits.name_len;
      PH_VALUE:     limit = limits.value_len;
      PH_VALUE_LWS: limit = limits.value_len;
      default:      limit = '0;
    endcase
  end

  assign room = (len_r < limit);

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    if (word.kind) begin
      phase_nxt = PH_START;
      len_nxt   = '0;
    end else begin
      case (phase_r)
        PH_START: begin
          if (c_tok) begin
            phase_nxt = PH_METHOD;
            len_nxt   = LEN_W'(1);
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_METHOD: begin
          if (c_tok) begin
            if (room) len_nxt = len_r + LEN_W'(1);
            else phase_nxt = PH_LONG_METHOD;
          end else if (c_sp) begin
            phase_nxt = PH_MU_GAP;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_MU_GAP: begin
          if (!c_sp) begin
            if (c_vis) begin
              phase_nxt = PH_URI;
              len_nxt   = LEN_W'(1);
            end else begin
              phase_nxt = PH_BAD;
            end
          end
        end
        PH_URI: begin
          if (c_vis) begin
            if (room) len_nxt = len_r + LEN_W'(1);
            else phase_nxt = PH_LONG_URI;
          end else if (c_sp) begin
            phase_nxt = PH_UV_GAP;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_UV_GAP: begin
          if (!c_sp) begin
            if (c_vis) begin
              phase_nxt = PH_VERSION;
              len_nxt   = LEN_W'(1);
            end else begin
              phase_nxt = PH_BAD;
            end
          end
        end
        PH_VERSION: begin
          if (c_sp) begin
            phase_nxt = PH_VER_CR;
          end else if (c_cr) begin
            phase_nxt = PH_VER_LF;
          end else if (c_vis) begin
            if (room) len_nxt = len_r + LEN_W'(1);
            else phase_nxt = PH_LONG_VERSION;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_VER_CR: begin
          if (!c_sp) phase_nxt = c_cr ? PH_VER_LF : PH_BAD;
        end
        PH_VER_LF: begin
          phase_nxt = c_lf ? PH_HDR : PH_BAD;
        end
        PH_HDR: begin
          len_nxt = '0;
          if (c_cr) begin
            phase_nxt = PH_END_LF;
          end else if (c_colon) begin
            phase_nxt = PH_VALUE;
          end else if (c_hdr) begin
            phase_nxt = PH_NAME;
            len_nxt   = LEN_W'(1);
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_NAME: begin
          if (c_colon) begin
            phase_nxt = PH_VALUE;
            len_nxt   = '0;
          end else if (!c_cr && c_hdr) begin
            if (room) len_nxt = len_r + LEN_W'(1);
            else phase_nxt = PH_LONG_NAME;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_VALUE: begin
          if (c_cr) begin
            phase_nxt = PH_VALUE_LF;
          end else if (c_hdr) begin
            if (room) len_nxt = len_r + LEN_W'(1);
            else phase_nxt = PH_LONG_VALUE;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_VALUE_LF: begin
          phase_nxt = c_lf ? PH_VALUE_LWS : PH_BAD;
        end
        PH_VALUE_LWS: begin
          if (c_cr) begin
            phase_nxt = PH_END_LF;
          end else if (c_colon) begin
            phase_nxt = PH_VALUE;
            len_nxt   = '0;
          end else if (c_sp) begin
            // A continuation line folds into one space of the value.
            if (room) begin
              phase_nxt = PH_VALUE;
              len_nxt   = len_r + LEN_W'(1);
            end else begin
              phase_nxt = PH_LONG_VALUE;
            end
          end else if (c_hdr) begin
            phase_nxt = PH_NAME;
            len_nxt   = LEN_W'(1);
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_END_LF: begin
          phase_nxt = c_lf ? PH_COMPLETE : PH_BAD;
        end
        PH_COMPLETE, PH_BAD, PH_LONG_METHOD, PH_LONG_URI, PH_LONG_VERSION,
        PH_LONG_NAME, PH_LONG_VALUE: begin
          phase_nxt = phase_r;
        end
        default: phase_nxt = PH_BAD;
      endcase
    end
  end

  // Outputs.
  always_comb begin
    cls  = CLS_NONE;
    ev   = EV_NONE;
    fold = 1'b0;
    if (!word.kind) begin
      case (phase_r)
        PH_START: begin
          if (c_tok) cls = CLS_METHOD;
        end
        PH_METHOD: begin
          if (c_tok) begin
            if (room) cls = CLS_METHOD;
          end else if (c_sp) begin
            ev = EV_METHOD;
          end
        end
        PH_MU_GAP: begin
          if (!c_sp && c_vis) cls = CLS_URI;
        end
        PH_URI: begin
          if (c_vis) begin
            if (room) cls = CLS_URI;
          end else if (c_sp) begin
            ev = EV_URI;
          end
        end
        PH_UV_GAP: begin
          if (!c_sp && c_vis) cls = CLS_VERSION;
        end
        PH_VERSION: begin
          if (c_sp || c_cr) ev = EV_VERSION;
          else if (c_vis && room) cls = CLS_VERSION;
        end
        PH_HDR: begin
          if (!c_cr && !c_colon && c_hdr) cls = CLS_NAME;
        end
        PH_NAME: begin
          if (!c_colon && !c_cr && c_hdr && room) cls = CLS_NAME;
        end
        PH_VALUE: begin
          if (!c_cr && c_hdr && room) cls = CLS_VALUE;
        end
        PH_VALUE_LWS: begin
          if (c_cr || c_colon) begin
            ev = EV_FIELD;
          end else if (c_sp) begin
            if (room) begin
              cls  = CLS_VALUE;
              fold = 1'b1;
            end
          end else if (c_hdr) begin
            ev  = EV_FIELD;
            cls = CLS_NAME;
          end
        end
        PH_END_LF: begin
          if (c_lf) ev = EV_COMPLETE;
        end
        default: begin
          cls = CLS_NONE;
          ev  = EV_NONE;
        end
      endcase
    end
  end

  assign result.byte_class = cls;
  assign result.out_byte   = (cls == CLS_NONE) ? 8'h00 : (fold ? CH_SP : c);
  assign result.done_event = ev;
  assign result.status     = status_of(phase_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      len_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
    end
  end

  // A byte is only appended while the request is still being parsed.
  a_cls_parsing: assert property (@(posedge clk) disable iff (!rst_n)
    (step && result.byte_class != CLS_NONE) |-> result.status == ST_PARSING)
    else $error("byte appended with a terminal status");

  // Complete and error phases hold until a restart word.
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !word.kind && phase_r >= PH_COMPLETE) |=> phase_r == $past(phase_r))
    else $error("terminal phase left without restart");

  a_complete_status: assert property (@(posedge clk) disable iff (!rst_n)
    (step && result.done_event == EV_COMPLETE) |-> result.status == ST_COMPLETE)
    else $error("request complete event without complete status");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && word.kind) |=> (phase_r == PH_START && len_r == '0))
    else $error("restart did not return to request start");

endmodule

>>> rtl/http_request_head_parser.sv
// HTTP request head parser, one byte per word.
// Input channel: in_valid / in_stall / in_data. A data word (kind 0) carries
// one byte of the request head; a restart word (kind 1) returns the parser to
// the start of a request and yields an all-zero result.
// Result channel: out_valid / out_stall / out_data. Every input word yields
// exactly one result word: the field the byte belongs to, the byte to append
// (a space for a folded continuation line), a field-done event and the
// status after this byte. Complete and error status stay until a restart.
// Configuration: cfg_we / cfg_index / cfg_wdata write the five length limits
// (method, URI, version, name, value); write them only while no word is
// in flight.
// A word is captured in the input register, and its result then moves into
// the output register once that register is free. One word is accepted
// every cycle while the result is not stalled; the loop through the phase
// and length registers sets that rate.
// At reset the limits take their defaults and the parser waits for the first
// method byte. While out_stall is high the result holds, the input register
// fills, and then in_stall rises until the result is taken.
module http_request_head_parser
  import hrhp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic      s1_valid_r;
  in_word_t  s1_data_r;
  logic      out_valid_r;
  out_word_t out_data_r;
  logic      advance;
  logic      in_take;
  limits_t   limits;
  out_word_t result;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  hrhp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .limits    (limits)
  );

  hrhp_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .word   (s1_data_r),
    .limits (limits),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) s1_valid_r <= 1'b1;
      else if (advance) s1_valid_r <= 1'b0;
      if (advance) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
    if (advance) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed word did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !advance)
    else $error("stalled result overwritten");

endmodule

>>> verif/http_request_head_parser_tb.sv
module http_request_head_parser_tb;
  import hrhp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 4;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // One row of the directed table: the word, how many times it is sent, and
  // an optional typed expectation that applies to the last of the repetitions.
  typedef struct packed {
    logic       typed;
    logic [7:0] reps;
    in_word_t   w;
    out_word_t  want;
  } dir_row_t;

  localparam out_word_t ZERO_RESULT = '0;
  localparam out_word_t BAD_RESULT  = '{CLS_NONE, 8'h00, EV_NONE, ST_BAD};

  localparam dir_row_t DIR_ROWS [24] = '{
    '{1'b1, 8'd1,  '{KIND_RESTART, 8'hFF}, ZERO_RESULT},
    '{1'b1, 8'd1,  '{KIND_DATA, "G"}, '{CLS_METHOD, "G", EV_NONE, ST_PARSING}},
    '{1'b0, 8'd1,  '{KIND_DATA, "E"}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, CH_SP}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, "/"}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, CH_HT}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, "H"}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, CH_CR}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, CH_LF}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, CH_COLON}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, "v"}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, CH_CR}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, CH_LF}, ZERO_RESULT},
    '{1'b1, 8'd1,  '{KIND_DATA, CH_HT}, '{CLS_VALUE, CH_SP, EV_NONE, ST_PARSING}},
    '{1'b0, 8'd1,  '{KIND_DATA, 8'hFF}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, CH_CR}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, CH_LF}, ZERO_RESULT},
    '{1'b0, 8'd1,  '{KIND_DATA, "N"}, ZERO_RESULT},
    '{1'b1, 8'd1,  '{KIND_DATA, CH_CR}, BAD_RESULT},
    '{1'b1, 8'd1,  '{KIND_DATA, "Q"}, BAD_RESULT},
    '{1'b1, 8'd1,  '{KIND_RESTART, 8'h00}, ZERO_RESULT},
    '{1'b1, 8'd21, '{KIND_DATA, "M"}, '{CLS_NONE, 8'h00, EV_NONE, ST_LONG_METHOD}},
    '{1'b1, 8'd1,  '{KIND_RESTART, 8'h00}, ZERO_RESULT},
    '{1'b1, 8'd1,  '{KIND_DATA, CH_DEL}, BAD_RESULT}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  http_request_head_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted parser state and the limits it works against.
  phase_t           exp_phase;
  logic [LEN_W-1:0] exp_len;
  limits_t          cur_limits;

  out_word_t pending_results[$];
  logic [7:0] req_bytes[$];

  int  err_cnt;
  int  n_words;
  int  n_results;
  int  n_complete;
  int  n_failed;
  int  cycle_cnt;
  int  in_idle_pct;
  int  out_idle_pct;
  bit  hold_request;
  out_word_t want;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic bit is_sp(logic [7:0] c);
    return c == CH_SP || c == CH_HT;
  endfunction

  function automatic bit is_vis(logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7E;
  endfunction

  function automatic bit is_hdr(logic [7:0] c);
    return c == CH_HT || (c >= CH_SP && c != CH_DEL);
  endfunction

  function automatic bit is_tok(logic [7:0] c);
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
      "{", "}": return 1'b0;
      default: return is_vis(c);
    endcase
  endfunction

  function automatic bit has_room(logic [LEN_W-1:0] limit);
    return exp_len < limit;
  endfunction

  function automatic logic [2:0] status_for(phase_t p);
    case (p)
      PH_COMPLETE:     return ST_COMPLETE;
      PH_BAD:          return ST_BAD;
      PH_LONG_METHOD:  return ST_LONG_METHOD;
      PH_LONG_URI:     return ST_LONG_URI;
      PH_LONG_VERSION: return ST_LONG_VERSION;
      PH_LONG_NAME:    return ST_LONG_NAME;
      PH_LONG_VALUE:   return ST_LONG_VALUE;
      default:         return ST_PARSING;
    endcase
  endfunction

  // Advances the predicted parser by one word and returns the result it owes.
  function automatic out_word_t next_parse_result(in_word_t w);
    out_word_t  r;
    phase_t     p;
    logic [7:0] c;
    logic [2:0] cls;
    logic [2:0] ev;
    r = '0;
    c = w.in_byte;
    cls = CLS_NONE;
    ev = EV_NONE;
    p = exp_phase;
    if (w.kind == KIND_RESTART) begin
      exp_phase = PH_START;
      exp_len = '0;
      return r;
    end
    case (exp_phase)
      PH_START: begin
        if (is_tok(c)) begin
          p = PH_METHOD; exp_len = LEN_W'(1); cls = CLS_METHOD;
        end else p = PH_BAD;
      end
      PH_METHOD: begin
        if (is_tok(c)) begin
          if (has_room(LEN_W'(cur_limits.method_len))) begin
            exp_len++; cls = CLS_METHOD;
          end else p = PH_LONG_METHOD;
        end else if (is_sp(c)) begin
          p = PH_MU_GAP; ev = EV_METHOD;
        end else p = PH_BAD;
      end
      PH_MU_GAP: begin
        if (is_sp(c)) p = PH_MU_GAP;
        else if (is_vis(c)) begin
          p = PH_URI; exp_len = LEN_W'(1); cls = CLS_URI;
        end else p = PH_BAD;
      end
      PH_URI: begin
        if (is_vis(c)) begin
          if (has_room(cur_limits.uri_len)) begin
            exp_len++; cls = CLS_URI;
          end else p = PH_LONG_URI;
        end else if (is_sp(c)) begin
          p = PH_UV_GAP; ev = EV_URI;
        end else p = PH_BAD;
      end
      PH_UV_GAP: begin
        if (is_sp(c)) p = PH_UV_GAP;
        else if (is_vis(c)) begin
          p = PH_VERSION; exp_len = LEN_W'(1); cls = CLS_VERSION;
        end else p = PH_BAD;
      end
      PH_VERSION: begin
        if (is_sp(c)) begin
          p = PH_VER_CR; ev = EV_VERSION;
        end else if (c == CH_CR) begin
          p = PH_VER_LF; ev = EV_VERSION;
        end else if (is_vis(c)) begin
          if (has_room(LEN_W'(cur_limits.version_len))) begin
            exp_len++; cls = CLS_VERSION;
          end else p = PH_LONG_VERSION;
        end else p = PH_BAD;
      end
      PH_VER_CR: begin
        if (is_sp(c)) p = PH_VER_CR;
        else p = (c == CH_CR) ? PH_VER_LF : PH_BAD;
      end
      PH_VER_LF: p = (c == CH_LF) ? PH_HDR : PH_BAD;
      PH_HDR: begin
        exp_len = '0;
        if (c == CH_CR) p = PH_END_LF;
        else if (c == CH_COLON) p = PH_VALUE;
        else if (is_hdr(c)) begin
          p = PH_NAME; exp_len = LEN_W'(1); cls = CLS_NAME;
        end else p = PH_BAD;
      end
      PH_NAME: begin
        if (c == CH_COLON) begin
          p = PH_VALUE; exp_len = '0;
        end else if (c != CH_CR && is_hdr(c)) begin
          if (has_room(cur_limits.name_len)) begin
            exp_len++; cls = CLS_NAME;
          end else p = PH_LONG_NAME;
        end else p = PH_BAD;
      end
      PH_VALUE: begin
        if (c == CH_CR) p = PH_VALUE_LF;
        else if (is_hdr(c)) begin
          if (has_room(cur_limits.value_len)) begin
            exp_len++; cls = CLS_VALUE;
          end else p = PH_LONG_VALUE;
        end else p = PH_BAD;
      end
      PH_VALUE_LF: p = (c == CH_LF) ? PH_VALUE_LWS : PH_BAD;
      PH_VALUE_LWS: begin
        if (c == CH_CR) begin
          ev = EV_FIELD; p = PH_END_LF;
        end else if (c == CH_COLON) begin
          ev = EV_FIELD; p = PH_VALUE; exp_len = '0;
        end else if (is_sp(c)) begin
          // A folded line adds one space, and that space counts as value.
          if (has_room(cur_limits.value_len)) begin
            exp_len++; cls = CLS_VALUE; c = CH_SP; p = PH_VALUE;
          end else p = PH_LONG_VALUE;
        end else if (is_hdr(c)) begin
          ev = EV_FIELD; p = PH_NAME; exp_len = LEN_W'(1); cls = CLS_NAME;
        end else p = PH_BAD;
      end
      PH_END_LF: begin
        if (c == CH_LF) begin
          p = PH_COMPLETE; ev = EV_COMPLETE;
        end else p = PH_BAD;
      end
      PH_COMPLETE, PH_BAD, PH_LONG_METHOD, PH_LONG_URI, PH_LONG_VERSION,
      PH_LONG_NAME, PH_LONG_VALUE: p = exp_phase;
      default: p = PH_BAD;
    endcase
    exp_phase = p;
    r.byte_class = cls;
    r.out_byte = (cls != CLS_NONE) ? c : 8'h00;
    r.done_event = ev;
    r.status = status_for(exp_phase);
    return r;
  endfunction

  function automatic logic [7:0] rand_tok();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7E)); while (!is_tok(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_text();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (!is_hdr(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_sp();
    return $urandom_range(0, 1) ? CH_SP : CH_HT;
  endfunction

  // Small limits get lengths that now and then run one past them.
  function automatic int pick_len(int lim);
    return $urandom_range(1, (lim <= 10) ? lim + 1 : 6);
  endfunction

  task automatic report(string what, int exp_val, int got_val);
    $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
             what, n_results, exp_val, got_val);
    err_cnt++;
  endtask

  // Offers one word, waits until it is taken, and records what it must yield.
  task automatic send_word(in_word_t w, bit typed = 1'b0, out_word_t typed_want = '0);
    out_word_t  pred;
    logic [2:0] st_before;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    st_before = status_for(exp_phase);
    pred = next_parse_result(w);
    if (pred.done_event == EV_COMPLETE) n_complete++;
    if (st_before == ST_PARSING && pred.status > ST_COMPLETE) n_failed++;
    pending_results.push_back(typed ? typed_want : pred);
    n_words++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_limits(limits_t l);
    write_reg(REG_METHOD_LEN, CFG_W'(l.method_len));
    write_reg(REG_URI_LEN, l.uri_len);
    write_reg(REG_VERSION_LEN, CFG_W'(l.version_len));
    write_reg(REG_NAME_LEN, l.name_len);
    write_reg(REG_VALUE_LEN, l.value_len);
    cfg_we <= 1'b0;
    cur_limits = l;
  endtask

  function automatic limits_t rand_limits();
    limits_t l;
    l.method_len = 8'($urandom_range(1, 8));
    l.uri_len = LEN_W'($urandom_range(1, 8));
    l.version_len = 8'($urandom_range(1, 8));
    l.name_len = LEN_W'($urandom_range(1, 8));
    l.value_len = LEN_W'($urandom_range(1, 10));
    return l;
  endfunction

  // Sends whole requests (restart first), mostly well formed with random
  // content; some are corrupted or cut short, and some chunks are pure noise.
  task automatic run_requests(int budget);
    int start;
    int n;
    int cut;
    in_word_t w;
    start = n_words;
    while (n_words - start < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          w.kind = ($urandom_range(0, 3) == 0) ? KIND_RESTART : KIND_DATA;
          w.in_byte = 8'($urandom_range(0, 255));
          send_word(w);
        end
      end else begin
        req_bytes.delete();
        repeat (pick_len(cur_limits.method_len)) req_bytes.push_back(rand_tok());
        repeat ($urandom_range(1, 2)) req_bytes.push_back(rand_sp());
        repeat (pick_len(cur_limits.uri_len)) req_bytes.push_back(8'($urandom_range(33, 126)));
        repeat ($urandom_range(1, 2)) req_bytes.push_back(rand_sp());
        repeat (pick_len(cur_limits.version_len))
          req_bytes.push_back(8'($urandom_range(33, 126)));
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) req_bytes.push_back(rand_sp());
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 7) != 0)
            repeat (pick_len(cur_limits.name_len)) req_bytes.push_back(rand_tok());
          req_bytes.push_back(CH_COLON);
          repeat (pick_len(cur_limits.value_len) - 1) req_bytes.push_back(rand_text());
          req_bytes.push_back(CH_CR);
          req_bytes.push_back(CH_LF);
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) begin
              req_bytes.push_back(rand_sp());
              repeat ($urandom_range(0, 3)) req_bytes.push_back(rand_text());
              req_bytes.push_back(CH_CR);
              req_bytes.push_back(CH_LF);
            end
          end
        end
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
        if ($urandom_range(0, 5) == 0)
          req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        cut = req_bytes.size();
        if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, req_bytes.size());
        w.kind = KIND_RESTART;
        w.in_byte = 8'($urandom_range(0, 255));
        send_word(w);
        w.kind = KIND_DATA;
        for (n = 0; n < cut; n++) begin
          w.in_byte = req_bytes[n];
          send_word(w);
        end
        // Sometimes one to three bytes follow; once a request has completed or failed they must leave its status alone.
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            w.in_byte = 8'($urandom_range(0, 255));
            send_word(w);
          end
        end
      end
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected result word", 0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.byte_class !== want.byte_class)
          report("byte_class", want.byte_class, out_data.byte_class);
        if (out_data.out_byte !== want.out_byte)
          report("out_byte", want.out_byte, out_data.out_byte);
        if (out_data.done_event !== want.done_event)
          report("done_event", want.done_event, out_data.done_event);
        if (out_data.status !== want.status)
          report("status", want.status, out_data.status);
      end
      n_results++;
    end
  end

  // Receiver side: random stall bursts, plus one long hold when asked.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending",
               cycle_cnt, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    limits_t l;
    int      i;
    int      k;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_METHOD_LEN;
    cfg_wdata <= '0;
    err_cnt = 0;
    n_words = 0;
    n_results = 0;
    n_complete = 0;
    n_failed = 0;
    cycle_cnt = 0;
    hold_request = 1'b0;
    in_idle_pct = 15;
    out_idle_pct = 15;
    exp_phase = PH_START;
    exp_len = '0;
    cur_limits = '{RST_METHOD_LEN, RST_URI_LEN, RST_VERSION_LEN, RST_NAME_LEN, RST_VALUE_LEN};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run against the limits left by reset.
    for (i = 0; i < 24; i++)
      for (k = 0; k < DIR_ROWS[i].reps; k++)
        send_word(DIR_ROWS[i].w, DIR_ROWS[i].typed && (k == DIR_ROWS[i].reps - 1),
                  DIR_ROWS[i].want);
    run_requests(150);
    drain();

    l = '{8'd1, 13'd1, 8'd1, 13'd1, 13'd1};
    load_limits(l);
    in_idle_pct = 30;
    out_idle_pct = 30;
    run_requests(150);
    drain();

    // Largest limits; the receiver holds off while the sender keeps offering.
    l = '{8'd255, 13'd8191, 8'd255, 13'd8191, 13'd8191};
    load_limits(l);
    in_idle_pct = 0;
    out_idle_pct = 10;
    hold_request = 1'b1;
    run_requests(120);
    in_idle_pct = 10;
    run_requests(60);
    drain();

    load_limits(rand_limits());
    in_idle_pct = 20;
    out_idle_pct = 20;
    run_requests(250);
    drain();

    load_limits(rand_limits());
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_requests(200);
    drain();

    $display("Covered %0d words under five limit settings, reset, minimum, maximum and random.",
             n_words);
    $display("Requests completed: %0d, requests ended by an error status: %0d.",
             n_complete, n_failed);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
